// File: sv/sfra_pkg.sv
// sfra_pkg: shared types, widths and helpers for the sliding frame aggregate
// used by sfra_front, sfra_back and sliding_frame_running_aggregate_unit
package sfra_pkg;

    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int PREC_W = 10;

    typedef struct packed {
        logic             new_part;
        logic             ok;
        logic [VAL_W-1:0] val;
    } t_item;

    function automatic logic f_less(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

// File: sv/sfra_front.sv
// sfra_front: accepts rows, flags partition starts, holds them in a two-entry queue
// depends on sfra_pkg
module sfra_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [sfra_pkg::KEY_W-1:0] i_part_key,
    input  logic                      i_key_null,
    input  logic [sfra_pkg::VAL_W-1:0] i_value,
    input  logic                      i_value_valid,
    output logic                      o_q_valid,
    output sfra_pkg::t_item           o_q_item,
    input  logic                      i_q_pop
);

    sfra_pkg::t_item                r_mem [2];
    logic                           r_wp, r_rp;
    logic [1:0]                     r_cnt;
    logic                           r_seen, r_prev_null;
    logic [sfra_pkg::KEY_W-1:0]     r_prev_key;
    logic [sfra_pkg::KEY_W-1:0]     key;
    logic                           push, pop;
    sfra_pkg::t_item                item;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];
    assign key       = i_key_null ? '0 : i_part_key;

    always_comb begin
        item.new_part = !r_seen || (i_key_null != r_prev_null) || (key != r_prev_key);
        item.ok       = i_value_valid;
        item.val      = i_value;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= item;
            r_prev_key  <= key;
        end
        if (!i_rst_n) begin
            r_wp        <= 1'b0;
            r_rp        <= 1'b0;
            r_cnt       <= 2'd0;
            r_seen      <= 1'b0;
            r_prev_null <= 1'b0;
        end else begin
            if (push) begin
                r_wp        <= !r_wp;
                r_seen      <= 1'b1;
                r_prev_null <= i_key_null;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: sv/sfra_back.sv
// sfra_back: row engine with value ring and min/max deques in memories
// depends on sfra_pkg; fed by sfra_front
module sfra_back #(
    parameter int MAX_FRAME = 1024,
    parameter int AW        = 10,
    parameter int CW        = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  sfra_pkg::t_item            i_q_item,
    output logic                       o_q_pop,
    input  logic [CW-1:0]              i_prec,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic [CW-1:0]              o_frame_rows,
    output logic [CW-1:0]              o_valid_count,
    output logic [sfra_pkg::VAL_W-1:0] o_frame_sum,
    output logic [sfra_pkg::VAL_W-1:0] o_frame_min,
    output logic [sfra_pkg::VAL_W-1:0] o_frame_max
);

    localparam int VW = sfra_pkg::VAL_W;
    localparam int DW = AW + VW;
    localparam logic [CW:0] LIM = (CW+1)'(MAX_FRAME);
    localparam logic [AW-1:0] LAST = AW'(MAX_FRAME - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EVCHK, S_EVUPD, S_ENTER, S_POPCHK, S_POPUPD, S_PUSH, S_HEADRD, S_OUT
    } t_state;

    t_state          r_state, n_state;
    logic [VW-1:0]   r_val, n_val;
    logic            r_ok, n_ok;
    logic [AW-1:0]   r_row_pos, n_row_pos;
    logic [CW-1:0]   r_rif, n_rif;
    logic [VW-1:0]   r_sum, n_sum;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_mhead, n_mhead, r_xhead, n_xhead;
    logic [CW-1:0]   r_mcnt, n_mcnt, r_xcnt, n_xcnt;
    logic            r_mdone, n_mdone, r_xdone, n_xdone;
    logic            r_mrd, n_mrd, r_xrd, n_xrd;

    logic [VW:0]     r_ring [MAX_FRAME];
    logic [DW-1:0]   r_mdq  [MAX_FRAME];
    logic [DW-1:0]   r_xdq  [MAX_FRAME];
    logic [VW:0]     r_ring_q;
    logic [DW-1:0]   r_mdq_q, r_xdq_q;

    logic [AW-1:0]   old_idx, m_tail, m_push, x_tail, x_push, m_addr, x_addr;
    logic [CW:0]     pos_ext, rif_ext;
    logic            any_val;

    function automatic logic [AW-1:0] f_wrap(input logic [CW:0] s);
        logic [CW:0] t;
        t = (s >= LIM) ? (s - LIM) : s;
        return t[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        return (a == LAST) ? '0 : a + 1'b1;
    endfunction

    always_comb begin
        pos_ext = (CW+1)'(r_row_pos);
        rif_ext = (CW+1)'(r_rif);
        old_idx = (pos_ext >= rif_ext) ? AW'(pos_ext - rif_ext)
                                       : AW'(pos_ext + LIM - rif_ext);
        m_push  = f_wrap((CW+1)'(r_mhead) + (CW+1)'(r_mcnt));
        m_tail  = f_wrap((CW+1)'(r_mhead) + (CW+1)'(r_mcnt) - 1'b1);
        x_push  = f_wrap((CW+1)'(r_xhead) + (CW+1)'(r_xcnt));
        x_tail  = f_wrap((CW+1)'(r_xhead) + (CW+1)'(r_xcnt) - 1'b1);
        m_addr  = (r_state == S_POPCHK) ? m_tail : r_mhead;
        x_addr  = (r_state == S_POPCHK) ? x_tail : r_xhead;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ENTER) begin
            r_ring[r_row_pos] <= {r_ok, r_val};
        end
        r_ring_q <= r_ring[old_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH) begin
            r_mdq[m_push] <= {r_row_pos, r_val};
        end
        r_mdq_q <= r_mdq[m_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH) begin
            r_xdq[x_push] <= {r_row_pos, r_val};
        end
        r_xdq_q <= r_xdq[x_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_val     = r_val;
        n_ok      = r_ok;
        n_row_pos = r_row_pos;
        n_rif     = r_rif;
        n_sum     = r_sum;
        n_cnt     = r_cnt;
        n_mhead   = r_mhead;
        n_xhead   = r_xhead;
        n_mcnt    = r_mcnt;
        n_xcnt    = r_xcnt;
        n_mdone   = r_mdone;
        n_xdone   = r_xdone;
        n_mrd     = r_mrd;
        n_xrd     = r_xrd;
        o_q_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_val   = i_q_item.val;
                    n_ok    = i_q_item.ok;
                    if (i_q_item.new_part) begin
                        n_row_pos = '0;
                        n_rif     = '0;
                        n_sum     = '0;
                        n_cnt     = '0;
                        n_mhead   = '0;
                        n_xhead   = '0;
                        n_mcnt    = '0;
                        n_xcnt    = '0;
                    end
                    n_state = S_EVCHK;
                end
            end
            S_EVCHK: begin
                n_state = (r_rif > i_prec) ? S_EVUPD : S_ENTER;
            end
            S_EVUPD: begin
                if (r_ring_q[VW]) begin
                    n_sum = r_sum - r_ring_q[VW-1:0];
                    n_cnt = r_cnt - 1'b1;
                end
                if (r_mcnt != '0 && r_mdq_q[DW-1:VW] == old_idx) begin
                    n_mhead = f_inc(r_mhead);
                    n_mcnt  = r_mcnt - 1'b1;
                end
                if (r_xcnt != '0 && r_xdq_q[DW-1:VW] == old_idx) begin
                    n_xhead = f_inc(r_xhead);
                    n_xcnt  = r_xcnt - 1'b1;
                end
                n_rif   = r_rif - 1'b1;
                n_state = S_EVCHK;
            end
            S_ENTER: begin
                n_mdone = 1'b0;
                n_xdone = 1'b0;
                if (r_ok) begin
                    n_sum   = r_sum + r_val;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_POPCHK;
                end else begin
                    n_state = S_HEADRD;
                end
            end
            S_POPCHK: begin
                n_mrd = !r_mdone && (r_mcnt != '0);
                n_xrd = !r_xdone && (r_xcnt != '0);
                if (!n_mrd) n_mdone = 1'b1;
                if (!n_xrd) n_xdone = 1'b1;
                n_state = (n_mrd || n_xrd) ? S_POPUPD : S_PUSH;
            end
            S_POPUPD: begin
                if (r_mrd) begin
                    if (sfra_pkg::f_less(r_mdq_q[VW-1:0], r_val)) n_mdone = 1'b1;
                    else n_mcnt = r_mcnt - 1'b1;
                end
                if (r_xrd) begin
                    if (sfra_pkg::f_less(r_val, r_xdq_q[VW-1:0])) n_xdone = 1'b1;
                    else n_xcnt = r_xcnt - 1'b1;
                end
                n_state = S_POPCHK;
            end
            S_PUSH: begin
                n_mcnt  = r_mcnt + 1'b1;
                n_xcnt  = r_xcnt + 1'b1;
                n_state = S_HEADRD;
            end
            S_HEADRD: begin
                n_rif     = r_rif + 1'b1;
                n_row_pos = f_inc(r_row_pos);
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_ok      <= n_ok;
        r_mdone   <= n_mdone;
        r_xdone   <= n_xdone;
        r_mrd     <= n_mrd;
        r_xrd     <= n_xrd;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_pos <= '0;
            r_rif     <= '0;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_mhead   <= '0;
            r_xhead   <= '0;
            r_mcnt    <= '0;
            r_xcnt    <= '0;
        end else begin
            r_state   <= n_state;
            r_row_pos <= n_row_pos;
            r_rif     <= n_rif;
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
            r_mhead   <= n_mhead;
            r_xhead   <= n_xhead;
            r_mcnt    <= n_mcnt;
            r_xcnt    <= n_xcnt;
        end
    end

    assign any_val       = (r_cnt != '0) && (r_mcnt != '0) && (r_xcnt != '0);
    assign o_res_valid   = (r_state == S_OUT);
    assign o_frame_rows  = r_rif;
    assign o_valid_count = r_cnt;
    assign o_frame_sum   = r_sum;
    assign o_frame_min   = any_val ? r_mdq_q[VW-1:0] : '0;
    assign o_frame_max   = any_val ? r_xdq_q[VW-1:0] : '0;

endmodule

// File: sv/sliding_frame_running_aggregate_unit.sv
// sliding_frame_running_aggregate_unit: top level, config register and output register
// depends on sfra_pkg, sfra_front, sfra_back
//
// One result per input row. The row engine runs an eviction check and update per row
// leaving the frame, then row entry, then, for a row with a non-null value only, rounds
// of deque back compares (min and max deques compare side by side, and the compare that
// stops a scan is a round too) and a push, then a head read and the output state. Each
// eviction and each round has a read state and an update state, from the single registered
// read port of the value ring and of each deque memory. Deque pops average about one per
// row. The output register holds each result; the engine pops the next row once it is taken.
// A two-entry request queue in front and an output register behind let either side
// stall on its own. Memories need no clearing after reset.
module sliding_frame_running_aggregate_unit #(
    parameter int MAX_FRAME = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic [sfra_pkg::PREC_W-1:0] i_cfg_wr_data,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // part_key [63:0], value [127:64]
    input  logic [127:0] i_s_axis_tdata,
    // key_null [0], value_valid [1]
    input  logic [1:0] i_s_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // frame_rows, valid_count, frame_sum, frame_min, frame_max, zero pad
    output logic [((2*$clog2(MAX_FRAME+1)+3*sfra_pkg::VAL_W+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int AW  = $clog2(MAX_FRAME);
    localparam int CW  = $clog2(MAX_FRAME+1);
    localparam int VW  = sfra_pkg::VAL_W;
    localparam int OW  = 2*CW + 3*VW;
    localparam int OWB = ((OW+7)/8)*8;
    localparam int EW  = (CW > sfra_pkg::PREC_W) ? CW : sfra_pkg::PREC_W;
    localparam logic [EW-1:0] PMAX = EW'(MAX_FRAME - 1);

    logic [sfra_pkg::PREC_W-1:0] r_prec;
    logic [EW-1:0]   prec_ext;
    logic [CW-1:0]   prec_eff;
    logic            q_valid, q_pop;
    sfra_pkg::t_item q_item;
    logic            res_valid, res_ready, take;
    logic [CW-1:0]   res_rows, res_cnt;
    logic [VW-1:0]   res_sum, res_min, res_max;
    logic            r_o_valid;
    logic [CW-1:0]   r_o_rows, r_o_cnt;
    logic [VW-1:0]   r_o_sum, r_o_min, r_o_max;

    assign prec_ext = EW'(r_prec);
    assign prec_eff = (prec_ext > PMAX) ? CW'(PMAX) : CW'(prec_ext);

    sfra_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_part_key    (i_s_axis_tdata[63:0]),
        .i_key_null    (i_s_axis_tuser[0]),
        .i_value       (i_s_axis_tdata[127:64]),
        .i_value_valid (i_s_axis_tuser[1]),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    sfra_back #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW),
        .CW        (CW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .i_prec        (prec_eff),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_frame_rows  (res_rows),
        .o_valid_count (res_cnt),
        .o_frame_sum   (res_sum),
        .o_frame_min   (res_min),
        .o_frame_max   (res_max)
    );

    assign res_ready = !r_o_valid || i_m_axis_tready;
    assign take      = res_valid && res_ready;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_rows <= res_rows;
            r_o_cnt  <= res_cnt;
            r_o_sum  <= res_sum;
            r_o_min  <= res_min;
            r_o_max  <= res_max;
        end
        if (!i_rst_n) begin
            r_prec    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_prec <= i_cfg_wr_data;
            if (take) r_o_valid <= 1'b1;
            else if (i_m_axis_tready) r_o_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = OWB'({r_o_max, r_o_min, r_o_sum, r_o_cnt, r_o_rows});

    a_rows_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_rows != '0))
        else $error("result with empty frame");

    a_count_le_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_cnt <= r_o_rows))
        else $error("non-null count exceeds frame rows");

    a_empty_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_cnt == '0) |-> (r_o_min == '0 && r_o_max == '0))
        else $error("min or max nonzero with no values");

endmodule
